// ===== rtl/cfri_pkg.sv =====
// Shared types and constants of the coalescing free-region table.
`default_nettype none
package cfri_pkg;

  localparam int unsigned DEF_MAX_REGIONS = 64;
  localparam int unsigned DEF_ADDR_BITS   = 32;

  localparam int unsigned START_W = 32;
  localparam int unsigned FSIZE_W = 32;
  localparam int unsigned RSIZE_W = 33;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_RES
  } cfri_state_e;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic fwd;
    logic bwd;
    logic ins;
  } cfri_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/cfri_if.sv =====
// Handshake channels for freed regions and insert results.
`default_nettype none
interface cfri_free_if;
  logic                          valid;
  logic                          ready;
  logic [cfri_pkg::START_W-1:0]  free_start;
  logic [cfri_pkg::FSIZE_W-1:0]  free_size;

  modport source (output valid, output free_start, output free_size, input ready);
  modport sink   (input valid, input free_start, input free_size, output ready);
endinterface

interface cfri_res_if;
  logic                          valid;
  logic                          ready;
  logic [cfri_pkg::START_W-1:0]  region_start;
  logic [cfri_pkg::RSIZE_W-1:0]  region_size;
  logic                          merged_after;
  logic                          merged_before;
  logic [cfri_pkg::COUNT_W-1:0]  entry_count;
  logic                          table_full;

  modport source (output valid, output region_start, output region_size,
                  output merged_after, output merged_before, output entry_count,
                  output table_full, input ready);
  modport sink   (input valid, input region_start, input region_size,
                  input merged_after, input merged_before, input entry_count,
                  input table_full, output ready);
endinterface
`default_nettype wire

// ===== rtl/cfri_cell.sv =====
// One entry of the sorted free-region chain with its compare and shift logic.
`default_nettype none
module cfri_cell #(
  parameter int unsigned AW    = 32,
  parameter int unsigned SW    = 33,
  parameter int unsigned SUM_W = 34
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire cfri_pkg::cfri_ctrl_t ctrl_i,
  input  wire                       valid_i,
  input  wire  [AW-1:0]             s_i,
  input  wire  [SW-1:0]             z_i,
  input  wire  [SUM_W-1:0]          sz_i,
  input  wire                       left_le_i,
  input  wire  [AW-1:0]             left_start_i,
  input  wire  [SW-1:0]             left_size_i,
  input  wire                       right_le_i,
  input  wire  [AW-1:0]             right_start_i,
  input  wire  [SW-1:0]             right_size_i,
  output logic                      le_o,
  output logic [AW-1:0]             start_o,
  output logic [SW-1:0]             size_o,
  output logic                      fwd_hit_o,
  output logic                      bwd_hit_o,
  output logic                      mark_o
);
  import cfri_pkg::*;

  // Merged sizes keep ADDR_BITS+1 bits.
  localparam logic [SW-1:0] MERGE_MASK = SW'({(AW + 1){1'b1}});

  logic [AW-1:0]    start_q, start_d;
  logic [SW-1:0]    size_q, size_d;
  logic             le_q, nxt_eq_q, prv_eq_q, mark_q;
  logic [SUM_W-1:0] end_sum;
  logic             at_pos;
  logic [SW-1:0]    merge_sum;

  assign end_sum   = SUM_W'(start_q) + SUM_W'(size_q);
  assign at_pos    = left_le_i & ~le_q;
  assign fwd_hit_o = at_pos & nxt_eq_q;
  assign bwd_hit_o = le_q & ~right_le_i & prv_eq_q;
  assign merge_sum = (size_q + z_i + ((ctrl_i.fwd && ctrl_i.bwd) ? right_size_i : '0))
                     & MERGE_MASK;

  always_comb begin
    start_d = start_q;
    size_d  = size_q;
    if (ctrl_i.upd_en) begin
      if (ctrl_i.fwd && ctrl_i.bwd) begin
        // close the gap: grow the entry before, pull the rest down by one
        if (bwd_hit_o) begin
          size_d = merge_sum;
        end else if (!le_q) begin
          start_d = right_start_i;
          size_d  = right_size_i;
        end
      end else if (ctrl_i.fwd) begin
        if (fwd_hit_o) begin
          start_d = s_i;
          size_d  = merge_sum;
        end
      end else if (ctrl_i.bwd) begin
        if (bwd_hit_o) begin
          size_d = merge_sum;
        end
      end else if (ctrl_i.ins) begin
        // open a slot: push entries from the insert point up by one
        if (at_pos) begin
          start_d = s_i;
          size_d  = z_i;
        end else if (!left_le_i) begin
          start_d = left_start_i;
          size_d  = left_size_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    size_q  <= size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q     <= 1'b0;
      nxt_eq_q <= 1'b0;
      prv_eq_q <= 1'b0;
      mark_q   <= 1'b0;
    end else begin
      if (ctrl_i.cmp_en) begin
        le_q     <= valid_i & (start_q <= s_i);
        nxt_eq_q <= valid_i & (SUM_W'(start_q) == sz_i);
        prv_eq_q <= end_sum == SUM_W'(s_i);
      end
      if (ctrl_i.upd_en) begin
        mark_q <= ctrl_i.bwd ? bwd_hit_o : fwd_hit_o;
      end
    end
  end

  assign le_o    = le_q;
  assign start_o = start_q;
  assign size_o  = size_q;
  assign mark_o  = mark_q;

endmodule
`default_nettype wire

// ===== rtl/coalescing_free_region_insert_core.sv =====
// Usage: address-ordered free-region table with coalescing, built as a cell chain.
// A freed region arrives on free_i (free_start, free_size) and is taken when
// valid and ready meet. It is placed in start order among the held regions and
// merged with the following and then the preceding region where they touch.
// One result beat per freed region leaves on res_o: the region now holding the
// freed space, the merge flags, the entry count and a flag for a dropped insert
// when the table is full.
// Timing: the chain of cells works on one region at a time, in these steps:
// accept, compare in every cell, update with one shift between neighbours,
// and load of the output register. The result is valid the cycle after that
// load step, and the next region can be taken in the same cycle that the result appears.
// A stalled receiver holds the result in the output register; the chain waits
// in its last step and accepts nothing new until the result can be loaded.
// Reset empties the table at once (entry count zero) and clears the output.
`default_nettype none
module coalescing_free_region_insert_core #(
  parameter int unsigned MAX_REGIONS = cfri_pkg::DEF_MAX_REGIONS,
  parameter int unsigned ADDR_BITS   = cfri_pkg::DEF_ADDR_BITS
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  cfri_free_if.sink  free_i,
  cfri_res_if.source res_o
);
  import cfri_pkg::*;

  localparam int unsigned AW    = ADDR_BITS;
  localparam int unsigned SW    = (ADDR_BITS + 1 > FSIZE_W) ? ADDR_BITS + 1 : FSIZE_W;
  localparam int unsigned SUM_W = SW + 1;
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

  cfri_state_e      state_q, state_d;
  cfri_ctrl_t       ctrl;
  logic [CNT_W-1:0] count_q, count_d;
  logic [AW-1:0]    s_q;
  logic [SW-1:0]    z_q;
  logic [SUM_W-1:0] sz_q;
  logic             fwd_q, bwd_q, full_q;
  logic             fwd_any, bwd_any;
  logic             accept, load_out;

  logic                  out_valid_q;
  logic [START_W-1:0]    out_start_q;
  logic [RSIZE_W-1:0]    out_size_q;
  logic                  out_after_q, out_before_q, out_full_q;
  logic [COUNT_W-1:0]    out_count_q;

  logic                c_le    [MAX_REGIONS];
  logic [AW-1:0]       c_start [MAX_REGIONS];
  logic [SW-1:0]       c_size  [MAX_REGIONS];
  logic                c_fwd   [MAX_REGIONS];
  logic                c_bwd   [MAX_REGIONS];
  logic                c_mark  [MAX_REGIONS];
  logic [AW-1:0]       sel_start;
  logic [SW-1:0]       sel_size;

  assign accept       = free_i.valid & free_i.ready;
  assign free_i.ready = (state_q == ST_IDLE);
  assign load_out     = (state_q == ST_RES) && (!out_valid_q || res_o.ready);

  always_comb begin
    fwd_any = 1'b0;
    bwd_any = 1'b0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      fwd_any = fwd_any | c_fwd[i];
      bwd_any = bwd_any | c_bwd[i];
    end
  end

  // Pick the entry that took the freed space.
  always_comb begin
    sel_start = '0;
    sel_size  = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      sel_start = sel_start | (c_mark[i] ? c_start[i] : '0);
      sel_size  = sel_size  | (c_mark[i] ? c_size[i]  : '0);
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ctrl        = '0;
    ctrl.fwd    = fwd_any;
    ctrl.bwd    = bwd_any;
    ctrl.ins    = ~fwd_any & ~bwd_any & (count_q < MAX_CNT);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CMP;
      end
      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        ctrl.upd_en = 1'b1;
        if (fwd_any && bwd_any) begin
          count_d = count_q - CNT_W'(1);
        end else if (ctrl.ins) begin
          count_d = count_q + CNT_W'(1);
        end
        state_d = ST_RES;
      end
      ST_RES: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      fwd_q   <= 1'b0;
      bwd_q   <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_UPD) begin
        fwd_q  <= fwd_any;
        bwd_q  <= bwd_any;
        full_q <= ~fwd_any & ~bwd_any & ~(count_q < MAX_CNT);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q  <= AW'(free_i.free_start);
      z_q  <= SW'(free_i.free_size);
      sz_q <= SUM_W'(AW'(free_i.free_start)) + SUM_W'(free_i.free_size);
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
      logic          left_le, right_le;
      logic [AW-1:0] left_start, right_start;
      logic [SW-1:0] left_size, right_size;

      if (g == 0) begin : g_first
        assign left_le    = 1'b1;
        assign left_start = '0;
        assign left_size  = '0;
      end else begin : g_mid_l
        assign left_le    = c_le[g-1];
        assign left_start = c_start[g-1];
        assign left_size  = c_size[g-1];
      end

      if (g == MAX_REGIONS - 1) begin : g_last
        assign right_le    = 1'b0;
        assign right_start = '0;
        assign right_size  = '0;
      end else begin : g_mid_r
        assign right_le    = c_le[g+1];
        assign right_start = c_start[g+1];
        assign right_size  = c_size[g+1];
      end

      cfri_cell #(
        .AW    (AW),
        .SW    (SW),
        .SUM_W (SUM_W)
      ) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (ctrl),
        .valid_i       (CNT_W'(g) < count_q),
        .s_i           (s_q),
        .z_i           (z_q),
        .sz_i          (sz_q),
        .left_le_i     (left_le),
        .left_start_i  (left_start),
        .left_size_i   (left_size),
        .right_le_i    (right_le),
        .right_start_i (right_start),
        .right_size_i  (right_size),
        .le_o          (c_le[g]),
        .start_o       (c_start[g]),
        .size_o        (c_size[g]),
        .fwd_hit_o     (c_fwd[g]),
        .bwd_hit_o     (c_bwd[g]),
        .mark_o        (c_mark[g])
      );
    end
  endgenerate

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (fwd_q || bwd_q) begin
        out_start_q <= START_W'(sel_start);
        out_size_q  <= RSIZE_W'(sel_size);
      end else begin
        out_start_q <= START_W'(s_q);
        out_size_q  <= RSIZE_W'(z_q);
      end
      out_after_q  <= fwd_q;
      out_before_q <= bwd_q;
      out_full_q   <= full_q;
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.region_start  = out_start_q;
  assign res_o.region_size   = out_size_q;
  assign res_o.merged_after  = out_after_q;
  assign res_o.merged_before = out_before_q;
  assign res_o.entry_count   = out_count_q;
  assign res_o.table_full    = out_full_q;

endmodule
`default_nettype wire
